>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions with an asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types and constants of the biquad section.
// ----------------------------------------------------------------------------
package bqd_pkg;

	localparam int DELAY_WIDTH     = 48;
	localparam int COEF_INT_BITS   = 4;
	localparam int CFG_INDEX_WIDTH = 3;

	// configuration register indices
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_B0,
		ST_CALC_Y,
		ST_MUL_A1,
		ST_MUL_B2,
		ST_UPD_D1,
		ST_UPD_D2
	} state_t;

	typedef enum logic [2:0] {
		MUL_B0,
		MUL_B1,
		MUL_B2,
		MUL_A1,
		MUL_A2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     prod_en;
		mul_sel_t mul_sel;
		logic     y_en;
		logic     acc_load;
		logic     acc_sub;
		logic     d1_en;
		logic     d2_en;
		logic     out_load;
	} cmd_t;

endpackage

>>> hw/rtl/bqd_ctrl.sv
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer for the biquad datapath and the input/output handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bqd_pkg::cmd_t cmd
);

	bqd_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bqd_pkg::ST_IDLE:   if (in_valid) state_d = bqd_pkg::ST_MUL_B0;
			bqd_pkg::ST_MUL_B0: state_d = bqd_pkg::ST_CALC_Y;
			bqd_pkg::ST_CALC_Y: state_d = bqd_pkg::ST_MUL_A1;
			bqd_pkg::ST_MUL_A1: state_d = bqd_pkg::ST_MUL_B2;
			bqd_pkg::ST_MUL_B2: state_d = bqd_pkg::ST_UPD_D1;
			bqd_pkg::ST_UPD_D1: state_d = bqd_pkg::ST_UPD_D2;
			bqd_pkg::ST_UPD_D2: if (out_free) state_d = bqd_pkg::ST_IDLE;
			default:            state_d = bqd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bqd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			bqd_pkg::ST_MUL_B0: begin
				cmd.prod_en = 1'b1;
				cmd.mul_sel = bqd_pkg::MUL_B0;
			end
			bqd_pkg::ST_CALC_Y: begin
				cmd.y_en    = 1'b1;
				cmd.prod_en = 1'b1;
				cmd.mul_sel = bqd_pkg::MUL_B1;
			end
			bqd_pkg::ST_MUL_A1: begin
				cmd.acc_load = 1'b1;
				cmd.prod_en  = 1'b1;
				cmd.mul_sel  = bqd_pkg::MUL_A1;
			end
			bqd_pkg::ST_MUL_B2: begin
				cmd.acc_sub = 1'b1;
				cmd.prod_en = 1'b1;
				cmd.mul_sel = bqd_pkg::MUL_B2;
			end
			bqd_pkg::ST_UPD_D1: begin
				// d1 takes the old accumulator plus d2; accumulator then takes b2*x
				cmd.d1_en    = 1'b1;
				cmd.acc_load = 1'b1;
				cmd.prod_en  = 1'b1;
				cmd.mul_sel  = bqd_pkg::MUL_A2;
			end
			bqd_pkg::ST_UPD_D2: begin
				cmd.d2_en    = out_free;
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bqd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_out_from_last, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == bqd_pkg::ST_UPD_D2), "result raised outside final step")
	`ASSERT_CLK(a_accept_starts, clk, arst_n, (in_valid && in_ready) |=> (state_q == bqd_pkg::ST_MUL_B0), "accepted item did not start")
	`ASSERT_CLK(a_stall_holds, clk, arst_n, (state_q == bqd_pkg::ST_UPD_D2 && out_valid_q && !out_ready) |=> (state_q == bqd_pkg::ST_UPD_D2 && out_valid_q), "result lost while stalled")
	`ASSERT_IMPL(a_d2_with_out, clk, arst_n, cmd.d2_en, cmd.out_load && out_free, "delay update without output transfer slot")

endmodule

>>> hw/rtl/bqd_datapath.sv
// ----------------------------------------------------------------------------
// bqd_datapath
// Coefficient registers, shared multiplier, accumulator and delay state.
// ----------------------------------------------------------------------------
module bqd_datapath #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [bqd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [COEF_WIDTH-1:0]                cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
	input  logic                                 clear_state,
	input  bqd_pkg::cmd_t                        cmd,
	output logic signed [SAMPLE_WIDTH-1:0]       sample_out
);

	localparam int PW   = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int DW   = bqd_pkg::DELAY_WIDTH;
	localparam int AW   = ((PW > DW) ? PW : DW) + 2;
	localparam int SUMW = ((PW + 1 > DW) ? PW + 1 : DW) + 1;
	localparam int FRAC = COEF_WIDTH - bqd_pkg::COEF_INT_BITS;

	localparam logic signed [AW-1:0] RND_HALF = {{(AW-1){1'b0}}, 1'b1} << (FRAC - 1);
	localparam logic signed [AW-1:0] Y_MAX = {{(AW-SAMPLE_WIDTH+1){1'b0}},
		{(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [AW-1:0] Y_MIN = {{(AW-SAMPLE_WIDTH+1){1'b1}},
		{(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [SUMW-1:0] D_MAX = {{(SUMW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] D_MIN = {{(SUMW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q, y_q, out_q;
	logic signed [PW-1:0]           prod_q;
	logic signed [PW:0]             acc_q;
	logic signed [DW-1:0]           d1_q, d2_q;

	logic signed [COEF_WIDTH-1:0]   coef_sel;
	logic signed [SAMPLE_WIDTH-1:0] opnd;
	logic signed [PW-1:0]           prod_d;
	logic signed [AW-1:0]           rnd_sum, rnd_shift;
	logic signed [SAMPLE_WIDTH-1:0] y_d;
	logic signed [SUMW-1:0]         sum_d1, sum_d2;

	function automatic logic signed [DW-1:0] sat_delay(input logic signed [SUMW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > D_MAX)
			r = D_MAX[DW-1:0];
		else if (v < D_MIN)
			r = D_MIN[DW-1:0];
		else
			r = v[DW-1:0];
		return r;
	endfunction

	// shared multiplier operand selection
	always_comb begin
		case (cmd.mul_sel)
			bqd_pkg::MUL_B0: coef_sel = b0_q;
			bqd_pkg::MUL_B1: coef_sel = b1_q;
			bqd_pkg::MUL_B2: coef_sel = b2_q;
			bqd_pkg::MUL_A1: coef_sel = a1_q;
			bqd_pkg::MUL_A2: coef_sel = a2_q;
			default:         coef_sel = b0_q;
		endcase
		opnd = (cmd.mul_sel == bqd_pkg::MUL_A1 || cmd.mul_sel == bqd_pkg::MUL_A2) ? y_q : x_q;
	end

	assign prod_d = PW'(coef_sel) * PW'(opnd);

	// round half up, floor shift, saturate to sample width
	assign rnd_sum   = AW'(prod_q) + AW'(d1_q) + RND_HALF;
	assign rnd_shift = rnd_sum >>> FRAC;

	always_comb begin
		if (rnd_shift > Y_MAX)
			y_d = Y_MAX[SAMPLE_WIDTH-1:0];
		else if (rnd_shift < Y_MIN)
			y_d = Y_MIN[SAMPLE_WIDTH-1:0];
		else
			y_d = rnd_shift[SAMPLE_WIDTH-1:0];
	end

	assign sum_d1 = SUMW'(acc_q) + SUMW'(d2_q);
	assign sum_d2 = SUMW'(acc_q) - SUMW'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					bqd_pkg::REG_B0: b0_q <= cfg_data;
					bqd_pkg::REG_B1: b1_q <= cfg_data;
					bqd_pkg::REG_B2: b2_q <= cfg_data;
					bqd_pkg::REG_A1: a1_q <= cfg_data;
					bqd_pkg::REG_A2: a2_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load && clear_state) begin
				d1_q <= '0;
				d2_q <= '0;
			end else begin
				if (cmd.d1_en)
					d1_q <= sat_delay(sum_d1);
				if (cmd.d2_en)
					d2_q <= sat_delay(sum_d2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			x_q <= sample_in;
		if (cmd.prod_en)
			prod_q <= prod_d;
		if (cmd.y_en)
			y_q <= y_d;
		if (cmd.acc_load)
			acc_q <= (PW+1)'(prod_q);
		else if (cmd.acc_sub)
			acc_q <= acc_q - (PW+1)'(prod_q);
		if (cmd.out_load)
			out_q <= y_q;
	end

	assign sample_out = out_q;

endmodule

>>> hw/rtl/biquad_iir_df2t_top.sv
// ----------------------------------------------------------------------------
// biquad_iir_df2t_top
// The result is registered in the final delay update step; no new sample is
// taken until that step is done, as the five products go through the single
// shared multiplier and the final delay update waits for a free output slot.
// Reset clears coefficients and both delays to zero; no clearing pass.
// ----------------------------------------------------------------------------
module biquad_iir_df2t_top #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bqd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COEF_WIDTH-1:0]               cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	input  logic                                clear_state,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);

	bqd_pkg::cmd_t cmd;

	bqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bqd_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_in   (sample_in),
		.clear_state (clear_state),
		.cmd         (cmd),
		.sample_out  (sample_out)
	);

endmodule
